[hdl/point_light_shade_core_macros.svh]
// Assertion macros shared by the point light shading core.
`ifndef POINT_LIGHT_SHADE_CORE_MACROS_SVH
`define POINT_LIGHT_SHADE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PLS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pls check failed");

// Next-cycle implication, checked outside reset
`define PLS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pls check failed");

`endif

[hdl/pls_pkg.sv]
// Shared widths and register codes for the point light shading core.
package pls_pkg;

    localparam int VEC_W  = 16;            // one packed lane
    localparam int COL_W  = 8;             // colour channel
    localparam int CFG_W  = 48;            // widest register
    localparam int S_W    = 34;            // squared distance
    localparam int R_W    = 17;            // distance, sqrt of S_W
    localparam int F_W    = 32;            // clamped dot product
    localparam int FC_W   = F_W + VEC_W;   // factor times light colour
    localparam int NUM_W  = FC_W + COL_W;  // full numerator
    localparam int DEN_W  = 51;            // denominator
    localparam int FRAC_SH = 28;           // final scale shift
    localparam int Q_W    = COL_W;         // quotient bits kept

    typedef enum logic [2:0] {
        REG_COLOR = 3'd0,
        REG_DIR   = 3'd1,
        REG_POS   = 3'd2,
        REG_KC    = 3'd3,
        REG_KL    = 3'd4,
        REG_KQ    = 3'd5
    } cfg_idx_t;

endpackage

[hdl/pls_sqrt_pipe.sv]
// Pipelined integer square root, one result bit per stage, with payload.
module pls_sqrt_pipe
    import pls_pkg::*;
#(
    parameter int PAY_W = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [S_W-1:0]   in_s,
    input  logic [PAY_W-1:0] in_pay,
    output logic             out_valid,
    output logic [S_W-1:0]   out_s,
    output logic [R_W-1:0]   out_root,
    output logic [PAY_W-1:0] out_pay
);

    logic [R_W:1]     vld_reg;
    logic [S_W-1:0]   s_reg    [1:R_W];
    logic [S_W-1:0]   rem_reg  [1:R_W];
    logic [R_W-1:0]   root_reg [1:R_W];
    logic [PAY_W-1:0] pay_reg  [1:R_W];

    genvar g;
    generate
        for (g = 0; g < R_W; g++) begin : g_stage
            localparam int BIT = R_W - 1 - g;
            logic             cur_v;
            logic [S_W-1:0]   cur_s;
            logic [S_W-1:0]   cur_rem;
            logic [R_W-1:0]   cur_root;
            logic [PAY_W-1:0] cur_pay;
            logic [S_W:0]     trial;
            logic             take;

            if (g == 0) begin : g_src_in
                assign cur_v    = in_valid;
                assign cur_s    = in_s;
                assign cur_rem  = in_s;
                assign cur_root = '0;
                assign cur_pay  = in_pay;
            end
            else begin : g_src_reg
                assign cur_v    = vld_reg[g];
                assign cur_s    = s_reg[g];
                assign cur_rem  = rem_reg[g];
                assign cur_root = root_reg[g];
                assign cur_pay  = pay_reg[g];
            end

            // trial = 2*root*2^BIT + 2^(2*BIT)
            assign trial = ({{(S_W + 1 - R_W){1'b0}}, cur_root} << (BIT + 1))
                         | ({{S_W{1'b0}}, 1'b1} << (2 * BIT));
            assign take  = ({1'b0, cur_rem} >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[g+1] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[g+1] <= cur_v;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    s_reg[g+1]   <= cur_s;
                    pay_reg[g+1] <= cur_pay;
                    if (take)
                    begin
                        rem_reg[g+1]  <= cur_rem - trial[S_W-1:0];
                        root_reg[g+1] <= cur_root | (R_W'(1) << BIT);
                    end
                    else
                    begin
                        rem_reg[g+1]  <= cur_rem;
                        root_reg[g+1] <= cur_root;
                    end
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[R_W];
    assign out_s     = s_reg[R_W];
    assign out_root  = root_reg[R_W];
    assign out_pay   = pay_reg[R_W];

endmodule

[hdl/pls_div_pipe.sv]
// Pipelined restoring divider: three numerators over one scaled denominator.
module pls_div_pipe
    import pls_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [DEN_W-1:0]            in_den,
    input  logic [2:0][NUM_W-1:0]       in_num,
    output logic                        out_valid,
    output logic [2:0][COL_W-1:0]       out_chan
);

    localparam int CMP_W = DEN_W + FRAC_SH + Q_W + 1;

    logic [Q_W:1]                vld_reg;
    logic [DEN_W-1:0]            den_reg  [1:Q_W];
    logic                        zero_reg [1:Q_W];
    logic [2:0]                  sat_reg  [1:Q_W];
    logic [2:0][NUM_W-1:0]       rem_reg  [1:Q_W];
    logic [2:0][Q_W-1:0]         q_reg    [1:Q_W];

    genvar g, c;
    generate
        for (g = 0; g < Q_W; g++) begin : g_stage
            localparam int BIT = Q_W - 1 - g;
            logic                  cur_v;
            logic [DEN_W-1:0]      cur_den;
            logic                  cur_zero;
            logic [2:0]            cur_sat;
            logic [2:0][NUM_W-1:0] cur_rem;
            logic [2:0][Q_W-1:0]   cur_q;
            logic [CMP_W-1:0]      dsh;
            logic [2:0]            take;
            logic [2:0][NUM_W-1:0] nxt_rem;
            logic [2:0][Q_W-1:0]   nxt_q;

            if (g == 0) begin : g_src_in
                logic [CMP_W-1:0] dtop;
                assign dtop     = {{(Q_W + 1){1'b0}}, in_den, {FRAC_SH{1'b0}}} << Q_W;
                assign cur_v    = in_valid;
                assign cur_den  = in_den;
                assign cur_zero = (in_den == '0);
                assign cur_rem  = in_num;
                assign cur_q    = '0;
                // quotient of 2^Q_W or more saturates
                for (c = 0; c < 3; c++) begin : g_sat
                    assign cur_sat[c] =
                        ({{(CMP_W - NUM_W){1'b0}}, in_num[c]} >= dtop);
                end
            end
            else begin : g_src_reg
                assign cur_v    = vld_reg[g];
                assign cur_den  = den_reg[g];
                assign cur_zero = zero_reg[g];
                assign cur_sat  = sat_reg[g];
                assign cur_rem  = rem_reg[g];
                assign cur_q    = q_reg[g];
            end

            assign dsh = {{(Q_W + 1){1'b0}}, cur_den, {FRAC_SH{1'b0}}} << BIT;

            for (c = 0; c < 3; c++) begin : g_chan
                assign take[c]    = ({{(CMP_W - NUM_W){1'b0}}, cur_rem[c]} >= dsh);
                assign nxt_rem[c] = take[c] ? (cur_rem[c] - dsh[NUM_W-1:0]) : cur_rem[c];
                assign nxt_q[c]   = take[c] ? (cur_q[c] | (Q_W'(1) << BIT)) : cur_q[c];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[g+1] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[g+1] <= cur_v;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[g+1]  <= cur_den;
                    zero_reg[g+1] <= cur_zero;
                    sat_reg[g+1]  <= cur_sat;
                    rem_reg[g+1]  <= nxt_rem;
                    q_reg[g+1]    <= nxt_q;
                end
            end
        end

        // zero denominator or large quotient gives full scale
        for (c = 0; c < 3; c++) begin : g_out
            assign out_chan[c] = (zero_reg[Q_W] || sat_reg[Q_W][c]) ? '1 : q_reg[Q_W][c];
        end
    endgenerate

    assign out_valid = vld_reg[Q_W];

endmodule

[hdl/point_light_shade_core.sv]
// Top level of the point light diffuse shading core.
//
// Usage:
//   Input items arrive on s_tvalid/s_tready/s_tdata, one per cycle at most:
//   surface normal (Q1.14), surface point (Q12.4) and base colour.
//   Results leave on m_tvalid/m_tready/m_tdata as three 8-bit channels.
//   Light colour, direction, position and the three attenuation terms are loaded
//   via cfg_we/cfg_index/cfg_data; the user must do so only while no item is in flight.
// Pipeline:
//   The pipeline has four front stages (differences and products,
//   squares and dot sum, distance sum and colour product, numerator),
//   17 square-root stages, two denominator stages and 8 divider stages.
//   It takes one item per cycle unless m_tready stalls it; every stage is a register.
// Reset:
//   rst_n clears all valid bits and loads the register reset values
//   (unit constant and linear terms, everything else zero).
// Back-pressure:
//   When m_tready is low with a result waiting, the whole pipeline holds
//   and s_tready drops; bubbles inside the pipeline are held, not squeezed out.
module point_light_shade_core
    import pls_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    // input stream
    input  logic             s_tvalid,
    output logic             s_tready,
    // normal_x, normal_y, normal_z, point_x, point_y, point_z,
    // base_red, base_green, base_blue
    input  logic [119:0]     s_tdata,
    // output stream
    output logic             m_tvalid,
    input  logic             m_tready,
    // lit_red, lit_green, lit_blue
    output logic [23:0]      m_tdata
);

`include "point_light_shade_core_macros.svh"

    // configuration registers
    logic [CFG_W-1:0] color_reg, dir_reg, pos_reg;
    logic [VEC_W-1:0] kc_reg, kl_reg, kq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= '0;
            dir_reg   <= '0;
            pos_reg   <= '0;
            kc_reg    <= VEC_W'(256);
            kl_reg    <= VEC_W'(256);
            kq_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_COLOR: color_reg <= cfg_data;
                REG_DIR:   dir_reg   <= cfg_data;
                REG_POS:   pos_reg   <= cfg_data;
                REG_KC:    kc_reg    <= cfg_data[VEC_W-1:0];
                REG_KL:    kl_reg    <= cfg_data[VEC_W-1:0];
                REG_KQ:    kq_reg    <= cfg_data[VEC_W-1:0];
                default:   ;
            endcase
        end
    end

    // global advance: hold everything while a result is stalled
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // stage A: position differences and direction products
    logic                    a_v_reg;
    logic signed [R_W-1:0]   a_diff_reg [3];
    logic signed [F_W-1:0]   a_prod_reg [3];
    logic [2:0][COL_W-1:0]   a_base_reg;

    // stage B: squares and clamped dot product
    logic                    b_v_reg;
    logic [2:0][F_W-1:0]     b_sq_reg;
    logic [F_W-1:0]          b_f_reg;
    logic [2:0][COL_W-1:0]   b_base_reg;

    // stage C: squared distance and factor times colour
    logic                    c_v_reg;
    logic [S_W-1:0]          c_s_reg;
    logic [2:0][FC_W-1:0]    c_fc_reg;
    logic [2:0][COL_W-1:0]   c_base_reg;

    // stage D: numerators
    logic                    d_v_reg;
    logic [S_W-1:0]          d_s_reg;
    logic [2:0][NUM_W-1:0]   d_num_reg;

    genvar k;
    generate
        for (k = 0; k < 3; k++) begin : g_lane
            logic signed [VEC_W-1:0] lpos, pt, ldir, nrm;
            logic signed [R_W-1:0]   diff;
            logic signed [2*R_W-1:0] sq;
            assign lpos = pos_reg[VEC_W*k +: VEC_W];
            assign ldir = dir_reg[VEC_W*k +: VEC_W];
            assign nrm  = s_tdata[VEC_W*k +: VEC_W];
            assign pt   = s_tdata[VEC_W*(k+3) +: VEC_W];
            assign diff = {lpos[VEC_W-1], lpos} - {pt[VEC_W-1], pt};
            assign sq   = a_diff_reg[k] * a_diff_reg[k];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_diff_reg[k] <= diff;
                    a_prod_reg[k] <= ldir * nrm;
                    a_base_reg[k] <= s_tdata[6*VEC_W + COL_W*k +: COL_W];
                    b_sq_reg[k]   <= sq[F_W-1:0];
                    b_base_reg[k] <= a_base_reg[k];
                    c_fc_reg[k]   <= b_f_reg * color_reg[VEC_W*k +: VEC_W];
                    c_base_reg[k] <= b_base_reg[k];
                    d_num_reg[k]  <= c_base_reg[k] * c_fc_reg[k];
                end
            end
        end
    endgenerate

    // negated dot sum, clamped at zero
    logic signed [F_W+1:0] dot_sum;
    assign dot_sum = -(F_W'(0) + {{2{a_prod_reg[0][F_W-1]}}, a_prod_reg[0]}
                             + {{2{a_prod_reg[1][F_W-1]}}, a_prod_reg[1]}
                             + {{2{a_prod_reg[2][F_W-1]}}, a_prod_reg[2]});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_f_reg <= (!dot_sum[F_W+1] && dot_sum != '0) ? dot_sum[F_W-1:0] : '0;
            c_s_reg <= {2'b00, b_sq_reg[0]} + {2'b00, b_sq_reg[1]} + {2'b00, b_sq_reg[2]};
            d_s_reg <= c_s_reg;
        end
    end

    // distance by square root, numerators ride along
    logic                  r_v;
    logic [S_W-1:0]        r_s;
    logic [R_W-1:0]        r_root;
    logic [3*NUM_W-1:0]    r_pay;

    pls_sqrt_pipe #(
        .PAY_W (3*NUM_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_v_reg),
        .in_s      (d_s_reg),
        .in_pay    (d_num_reg),
        .out_valid (r_v),
        .out_s     (r_s),
        .out_root  (r_root),
        .out_pay   (r_pay)
    );

    // stage E: attenuation products
    logic                     e_v_reg;
    logic [S_W-1:0]           e_s_reg;
    logic [R_W-1:0]           e_d_reg;
    logic [VEC_W+R_W-1:0]     e_lin_reg;
    logic [VEC_W+S_W-1:0]     e_quad_reg;
    logic [3*NUM_W-1:0]       e_num_reg;

    // stage F: denominator
    logic                     f_v_reg;
    logic [DEN_W-1:0]         f_den_reg;
    logic [3*NUM_W-1:0]       f_num_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_s_reg    <= r_s;
            e_d_reg    <= r_root;
            e_lin_reg  <= kl_reg * r_root;
            e_quad_reg <= kq_reg * r_s;
            e_num_reg  <= r_pay;
            f_den_reg  <= DEN_W'({kc_reg, 8'h00})
                        + DEN_W'({e_lin_reg, 4'h0})
                        + DEN_W'(e_quad_reg);
            f_num_reg  <= e_num_reg;
        end
    end

    // valid bits of the front and middle stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= s_tvalid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= r_v;
            f_v_reg <= e_v_reg;
        end
    end

    // channel division and saturation
    logic [2:0][COL_W-1:0] lit;

    pls_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_v_reg),
        .in_den    (f_den_reg),
        .in_num    (f_num_reg),
        .out_valid (m_tvalid),
        .out_chan  (lit)
    );

    assign m_tdata = lit;

    // checks
    logic [2*R_W+1:0] d_sq, d1_sq;
    assign d_sq  = {{(R_W+2){1'b0}}, e_d_reg} * {{(R_W+2){1'b0}}, e_d_reg};
    assign d1_sq = ({{(R_W+1){1'b0}}, e_d_reg} + 1'b1) * ({{(R_W+1){1'b0}}, e_d_reg} + 1'b1);

    `PLS_ASSERT_IMPL(a_root_low, e_v_reg, d_sq <= {2'b00, e_s_reg})
    `PLS_ASSERT_IMPL(a_root_high, e_v_reg, d1_sq > {2'b00, e_s_reg})
    `PLS_ASSERT_IMPL(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready)

endmodule
